>>> rtl/irti_pkg.sv
package irti_pkg;

    localparam int TABLE_CAP = 64;
    localparam int IDX_W = 6;
    localparam int BRK_W = 12;
    localparam int Q_W = 3;

    localparam logic [7:0] INVALID_CM = 8'hFF;
    localparam logic [8:0] MAX_CM = 9'd254;
    localparam logic [2:0] STEP_CM = 3'd5;
    localparam logic [IDX_W-1:0] BASE_INDEX = 6'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SEARCH,
        S_DIV,
        S_LOAD
    } t_state;

    typedef struct packed {
        logic             done;
        logic [IDX_W-1:0] seg;
    } t_search_res;

    // Falling breakpoint table; entries past the populated ones read as zero.
    function automatic logic [BRK_W-1:0] brk_entry(input logic [IDX_W-1:0] idx);
        logic [BRK_W-1:0] v;
        case (idx)
            6'd0: v = 12'd3618;
            6'd1: v = 12'd3271;
            6'd2: v = 12'd2867;
            6'd3: v = 12'd2492;
            6'd4: v = 12'd2210;
            6'd5: v = 12'd1987;
            6'd6: v = 12'd1795;
            6'd7: v = 12'd1639;
            6'd8: v = 12'd1506;
            6'd9: v = 12'd1394;
            6'd10: v = 12'd1287;
            6'd11: v = 12'd1204;
            6'd12: v = 12'd1124;
            6'd13: v = 12'd1061;
            6'd14: v = 12'd1002;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

>>> rtl/irti_seg_search.sv
module irti_seg_search #(
    parameter int TABLE_ENTRIES = 15,
    parameter int CW = 12
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [CW-1:0]          i_count,
    output irti_pkg::t_search_res  o_res
);

    localparam int N_ENT = (TABLE_ENTRIES < 2) ? 2 :
                           ((TABLE_ENTRIES > irti_pkg::TABLE_CAP) ? irti_pkg::TABLE_CAP :
                            TABLE_ENTRIES);
    localparam logic [irti_pkg::IDX_W-1:0] LAST_SEG = irti_pkg::IDX_W'(N_ENT - 2);

    logic                       r_busy;
    logic                       n_busy;
    logic                       r_done;
    logic                       n_done;
    logic [irti_pkg::IDX_W-1:0] r_seg;
    logic [irti_pkg::IDX_W-1:0] n_seg;
    logic [irti_pkg::IDX_W-1:0] w_next_idx;
    logic [CW-1:0]              w_lo;
    logic                       w_hit;

    assign w_next_idx = r_seg + 1'b1;
    assign w_lo = CW'(irti_pkg::brk_entry(w_next_idx));
    assign w_hit = (i_count >= w_lo) || (r_seg == LAST_SEG);

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_seg = r_seg;
        if (i_start) begin
            n_busy = 1'b1;
            n_seg = '0;
        end else if (r_busy && w_hit) begin
            n_busy = 1'b0;
            n_done = 1'b1;
        end else if (r_busy) begin
            n_seg = w_next_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_seg <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_seg <= n_seg;
        end
    end

    assign o_res.done = r_done;
    assign o_res.seg = r_seg;

endmodule

>>> rtl/irti_serial_div.sv
module irti_serial_div #(
    parameter int NW = 15
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [NW-1:0]            i_num,
    input  logic [NW-1:0]            i_den,
    output logic                     o_done,
    output logic [irti_pkg::Q_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(irti_pkg::Q_W);

    logic [NW-1:0]            r_rem;
    logic [NW-1:0]            n_rem;
    logic [NW-1:0]            r_den;
    logic [NW-1:0]            n_den;
    logic [irti_pkg::Q_W-1:0] r_quot;
    logic [irti_pkg::Q_W-1:0] n_quot;
    logic [CNT_W-1:0]         r_cnt;
    logic [CNT_W-1:0]         n_cnt;
    logic                     r_busy;
    logic                     n_busy;
    logic                     r_done;
    logic                     n_done;
    logic                     w_ge;
    logic [NW-1:0]            w_diff;

    assign w_ge = (r_rem >= r_den);
    assign w_diff = r_rem - r_den;

    // Restoring division, one quotient bit per cycle, most significant first.
    always_comb begin
        n_rem = r_rem;
        n_den = r_den;
        n_quot = r_quot;
        n_cnt = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_rem = i_num;
            n_den = i_den << (irti_pkg::Q_W - 1);
            n_quot = '0;
            n_cnt = CNT_W'(irti_pkg::Q_W - 1);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (w_ge) begin
                n_rem = w_diff;
            end
            n_quot = {r_quot[irti_pkg::Q_W-2:0], w_ge};
            n_den = r_den >> 1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_den <= n_den;
        r_quot <= n_quot;
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

>>> rtl/ir_range_table_interpolator_unit.sv
// Infrared range sensor linearizer: converts one converter count into a
// distance in centimeters by interpolating over a falling breakpoint table.
// The slave channel takes one count per beat; the master channel returns one
// result beat per count, with the distance in tdata and the out-of-range flag
// in tuser. A count outside the table span returns 255 with the flag set.
// Items are handled one at a time. After a beat is taken, a check state tests the
// span, the segment search then walks the table one breakpoint per cycle, and
// a bit-serial divider produces the three quotient bits. The next count is
// taken in the cycle after the result is loaded into the output register.
// The output register frees the core, so a stalled receiver blocks only the
// load of the following result, while that next count is still accepted.
// Synchronous reset clears the control state and drops the output valid.
module ir_range_table_interpolator_unit #(
    parameter int TABLE_ENTRIES = 15,
    parameter int ADC_BITS = 12
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // Fields from bit 0: adc_count.
    input  logic [((ADC_BITS+7)/8)*8-1:0]    i_s_tdata,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // Fields from bit 0: distance_cm.
    output logic [7:0]                       o_m_tdata,
    // Fields from bit 0: out_of_range.
    output logic [0:0]                       o_m_tuser
);

    localparam int CW = (ADC_BITS > irti_pkg::BRK_W) ? ADC_BITS : irti_pkg::BRK_W;
    localparam int NW = CW + 3;
    localparam int N_ENT = (TABLE_ENTRIES < 2) ? 2 :
                           ((TABLE_ENTRIES > irti_pkg::TABLE_CAP) ? irti_pkg::TABLE_CAP :
                            TABLE_ENTRIES);
    localparam logic [irti_pkg::IDX_W-1:0] LAST_IDX = irti_pkg::IDX_W'(N_ENT - 1);

    irti_pkg::t_state         r_state;
    irti_pkg::t_state         n_state;
    irti_pkg::t_search_res    w_res;
    logic [CW-1:0]            r_count;
    logic [7:0]               r_res_dist;
    logic                     r_res_oor;
    logic                     r_flat;
    logic [7:0]               r_m_tdata;
    logic                     r_m_tuser;
    logic                     r_m_valid;
    logic                     w_oor;
    logic                     w_search_start;
    logic                     w_div_start;
    logic                     w_out_load;
    logic                     w_out_free;
    logic                     w_div_done;
    logic [irti_pkg::Q_W-1:0] w_quot;
    logic [CW-1:0]            w_first;
    logic [CW-1:0]            w_last;
    logic [CW-1:0]            w_hi;
    logic [CW-1:0]            w_lo;
    logic [NW-1:0]            w_num;
    logic [NW-1:0]            w_den;
    logic [8:0]               w_base;
    logic [8:0]               w_sum;
    logic [7:0]               w_dist;

    assign w_first = CW'(irti_pkg::brk_entry('0));
    assign w_last = CW'(irti_pkg::brk_entry(LAST_IDX));
    assign w_oor = (r_count > w_first) || (r_count < w_last);

    assign w_hi = CW'(irti_pkg::brk_entry(w_res.seg));
    assign w_lo = CW'(irti_pkg::brk_entry(w_res.seg + 1'b1));
    assign w_num = NW'((NW'(w_hi) - NW'(r_count)) * NW'(irti_pkg::STEP_CM));
    assign w_den = NW'(w_hi - w_lo);

    assign w_base = 9'((10'(w_res.seg) + 10'(irti_pkg::BASE_INDEX)) *
                       10'(irti_pkg::STEP_CM));
    assign w_sum = w_base + (r_flat ? 9'd0 : 9'(w_quot));
    assign w_dist = (w_sum > irti_pkg::MAX_CM) ? irti_pkg::MAX_CM[7:0] : w_sum[7:0];

    assign w_out_free = !r_m_valid || i_m_tready;

    irti_seg_search #(
        .TABLE_ENTRIES(TABLE_ENTRIES),
        .CW(CW)
    ) u_search (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_search_start),
        .i_count(r_count),
        .o_res(w_res)
    );

    irti_serial_div #(
        .NW(NW)
    ) u_div (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_div_start),
        .i_num(w_num),
        .i_den(w_den),
        .o_done(w_div_done),
        .o_quot(w_quot)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            irti_pkg::S_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = irti_pkg::S_CHECK;
                end
            end
            irti_pkg::S_CHECK: begin
                n_state = w_oor ? irti_pkg::S_LOAD : irti_pkg::S_SEARCH;
            end
            irti_pkg::S_SEARCH: begin
                if (w_res.done) begin
                    n_state = irti_pkg::S_DIV;
                end
            end
            irti_pkg::S_DIV: begin
                if (w_div_done) begin
                    n_state = irti_pkg::S_LOAD;
                end
            end
            irti_pkg::S_LOAD: begin
                if (w_out_free) begin
                    n_state = irti_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = irti_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_s_tready = 1'b0;
        w_search_start = 1'b0;
        w_div_start = 1'b0;
        w_out_load = 1'b0;
        case (r_state)
            irti_pkg::S_IDLE: begin
                o_s_tready = 1'b1;
            end
            irti_pkg::S_CHECK: begin
                w_search_start = !w_oor;
            end
            irti_pkg::S_SEARCH: begin
                w_div_start = w_res.done;
            end
            irti_pkg::S_LOAD: begin
                w_out_load = w_out_free;
            end
            default: begin
                o_s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= irti_pkg::S_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_out_load) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_count <= CW'(i_s_tdata[ADC_BITS-1:0]);
        end
        if (r_state == irti_pkg::S_CHECK && w_oor) begin
            r_res_dist <= irti_pkg::INVALID_CM;
            r_res_oor <= 1'b1;
        end
        if (w_div_start) begin
            r_flat <= (w_den == '0);
        end
        if (r_state == irti_pkg::S_DIV && w_div_done) begin
            r_res_dist <= w_dist;
            r_res_oor <= 1'b0;
        end
        if (w_out_load) begin
            r_m_tdata <= r_res_dist;
            r_m_tuser <= r_res_oor;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata = r_m_tdata;
    assign o_m_tuser = r_m_tuser;

endmodule

>>> rtl/irti_checker.sv
module irti_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_s_tvalid,
    input logic       o_s_tready,
    input logic       o_m_tvalid,
    input logic       i_m_tready,
    input logic [7:0] o_m_tdata,
    input logic [0:0] o_m_tuser
);

    a_reset_clears_valid: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("Output valid seen after reset.");

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("Output valid dropped while stalled.");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("Second input beat taken while an item is in work.");

    a_flag_matches_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tuser[0] == (o_m_tdata == 8'hFF)))
        else $error("Out-of-range flag disagrees with the invalid distance.");

    a_in_range_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser[0] |-> o_m_tdata >= 8'd20)
        else $error("In-range distance below the first breakpoint distance.");

endmodule

bind ir_range_table_interpolator_unit irti_checker u_irti_checker (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .i_s_tvalid(i_s_tvalid),
    .o_s_tready(o_s_tready),
    .o_m_tvalid(o_m_tvalid),
    .i_m_tready(i_m_tready),
    .o_m_tdata(o_m_tdata),
    .o_m_tuser(o_m_tuser)
);

>>> verif/irti_checker.sv
`timescale 1ns / 1ps

module irti_scoreboard #(
    parameter int S_DATA_W = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    input  logic                i_s_tready,
    // Fields from bit 0: adc_count.
    input  logic [S_DATA_W-1:0] i_s_tdata,
    input  logic                i_m_tvalid,
    input  logic                i_m_tready,
    // Fields from bit 0: distance_cm.
    input  logic [7:0]          i_m_tdata,
    // Fields from bit 0: out_of_range.
    input  logic [0:0]          i_m_tuser,
    output int                  o_fail_count,
    output int                  o_pending
);

    localparam int N_BRK = 15;
    localparam int ADC_W = 12;

    localparam logic [N_BRK-1:0][11:0] BRK_CNT = {
        12'd1002, 12'd1061, 12'd1124, 12'd1204, 12'd1287,
        12'd1394, 12'd1506, 12'd1639, 12'd1795, 12'd1987,
        12'd2210, 12'd2492, 12'd2867, 12'd3271, 12'd3618
    };

    typedef struct packed {
        logic [7:0] distance_cm;
        logic       out_of_range;
    } t_range_res;

    t_range_res distance_q[$];
    int         fails = 0;

    function automatic t_range_res predict_range(input logic [S_DATA_W-1:0] word);
        t_range_res res;
        int         c;
        int         seg;
        int         hi;
        int         lo;
        int         span;
        int         frac;
        int         cm_val;
        bit         found;
        c = int'(word[ADC_W-1:0]);
        if (c > int'(BRK_CNT[0]) || c < int'(BRK_CNT[N_BRK-1])) begin
            res.distance_cm = irti_pkg::INVALID_CM;
            res.out_of_range = 1'b1;
            return res;
        end
        seg = N_BRK - 2;
        found = 1'b0;
        for (int k = 0; k + 2 < N_BRK; k++) begin
            if (!found && c >= int'(BRK_CNT[k+1])) begin
                seg = k;
                found = 1'b1;
            end
        end
        hi = int'(BRK_CNT[seg]);
        lo = int'(BRK_CNT[seg+1]);
        span = (hi > lo) ? hi - lo : 0;
        frac = (span != 0 && hi >= c) ? ((hi - c) * int'(irti_pkg::STEP_CM)) / span : 0;
        cm_val = (seg + int'(irti_pkg::BASE_INDEX)) * int'(irti_pkg::STEP_CM) + frac;
        if (cm_val > int'(irti_pkg::MAX_CM)) begin
            cm_val = int'(irti_pkg::MAX_CM);
        end
        res.distance_cm = 8'(cm_val);
        res.out_of_range = 1'b0;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_range_res want;
        if (i_rst_n) begin
            if (i_s_tvalid && i_s_tready) begin
                distance_q.push_back(predict_range(i_s_tdata));
            end
            if (i_m_tvalid && i_m_tready) begin
                if (distance_q.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected result beat, expected none, got %0d/%0d",
                             $time, i_m_tdata, i_m_tuser);
                end else begin
                    want = distance_q.pop_front();
                    if (i_m_tdata !== want.distance_cm) begin
                        fails++;
                        $display("%0t: distance_cm expected %0d, got %0d",
                                 $time, want.distance_cm, i_m_tdata);
                    end
                    if (i_m_tuser[0] !== want.out_of_range) begin
                        fails++;
                        $display("%0t: out_of_range expected %0d, got %0d",
                                 $time, want.out_of_range, i_m_tuser[0]);
                    end
                end
            end
        end
        o_pending <= distance_q.size();
        o_fail_count <= fails;
    end

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int S_DATA_W = 16;
    localparam int N_RANDOM = 1850;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_s_tvalid = 1'b0;
    logic                o_s_tready;
    // Fields from bit 0: adc_count.
    logic [S_DATA_W-1:0] i_s_tdata = '0;
    logic                o_m_tvalid;
    logic                i_m_tready = 1'b0;
    // Fields from bit 0: distance_cm.
    logic [7:0]          o_m_tdata;
    // Fields from bit 0: out_of_range.
    logic [0:0]          o_m_tuser;

    int fail_count;
    int pending;
    int rx_stall = 0;
    bit rx_idle_on = 1'b1;

    always #4 i_clk = ~i_clk;

    ir_range_table_interpolator_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    irti_scoreboard #(
        .S_DATA_W (S_DATA_W)
    ) u_scoreboard (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_m_tuser    (o_m_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else if (rx_stall > 0) begin
            rx_stall <= rx_stall - 1;
            i_m_tready <= 1'b0;
        end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
            rx_stall <= $urandom_range(0, 11);
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    task automatic send_count(input logic [S_DATA_W-1:0] word, input bit allow_gap);
        int gap;
        if (allow_gap && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 12);
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= word;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
    endtask

    function automatic logic [S_DATA_W-1:0] random_count();
        int pick;
        int k;
        int v;
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
            v = $urandom_range(1002, 3618);
        end else if (pick < 8) begin
            k = $urandom_range(0, 14);
            v = int'(irti_pkg::brk_entry(6'(k))) + $urandom_range(0, 4) - 2;
        end else begin
            v = $urandom_range(0, 4095);
        end
        return S_DATA_W'(v);
    endfunction

    initial begin
        bit idle_on;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_count(16'd0, 1'b1);
        send_count(16'd4095, 1'b1);
        send_count(16'd1001, 1'b1);
        send_count(16'd3619, 1'b1);
        for (int k = 0; k < 15; k++) begin
            send_count(S_DATA_W'(irti_pkg::brk_entry(6'(k))), 1'b1);
        end
        send_count(16'd1003, 1'b1);
        send_count(16'd3617, 1'b1);
        // Bits above the converter width must be ignored.
        send_count(16'hF7D0, 1'b1);
        send_count(16'hFFFF, 1'b1);

        for (int n = 0; n < N_RANDOM; n++) begin
            idle_on = (n < N_RANDOM - 200) && ((n / 150) % 3 != 2);
            rx_idle_on <= idle_on;
            if (n == N_RANDOM / 2) begin
                i_s_tvalid <= 1'b0;
                @(posedge i_clk);
                while (pending != 0) @(posedge i_clk);
            end
            send_count(random_count(), idle_on);
        end
        i_s_tvalid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("tb_top failed");
        $finish;
    end

endmodule
